@@ hw/rtl/idmr_pkg.sv @@
// Shared types and constants for the int8 dense MAC requantize block.
package idmr_pkg;

  localparam int ACT_W   = 8;
  localparam int BIAS_W  = 32;
  localparam int MULT_W  = 30;
  localparam int SHIFT_W = 7;
  localparam int PROD_W  = 18;

  localparam logic [1:0] REG_IZP = 2'd0;
  localparam logic [1:0] REG_WZP = 2'd1;
  localparam logic [1:0] REG_OZP = 2'd2;

  localparam logic [7:0] IZP_RESET = 8'h80;
  localparam logic [7:0] WZP_RESET = 8'h00;
  localparam logic [7:0] OZP_RESET = 8'h80;

  typedef struct packed {
    logic signed [7:0] izp;
    logic signed [7:0] wzp;
    logic signed [7:0] ozp;
  } idmr_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_RND,
    BK_SHF,
    BK_SAT
  } idmr_bstate_t;

endpackage

@@ hw/rtl/idmr_front.sv @@
// Front end: accepts words, multiplies the zero-point corrected pair and accumulates.
module idmr_front #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  idmr_pkg::idmr_cfg_t                   cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_act,
  input  logic [7:0]                            in_wgt,
  input  logic                                  in_last,
  input  logic [31:0]                           in_bias,
  input  logic [29:0]                           in_mult,
  input  logic [6:0]                            in_shift,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output logic [ACC_WIDTH+idmr_pkg::MULT_W+idmr_pkg::SHIFT_W-1:0] q_data
);

  logic signed [8:0]  a_diff;
  logic signed [8:0]  w_diff;
  logic signed [17:0] prod;

  logic               st_valid_r;
  logic signed [17:0] st_prod_r;
  logic               st_last_r;
  logic [31:0]        st_bias_r;
  logic [29:0]        st_mult_r;
  logic [6:0]         st_shift_r;
  logic [ACC_WIDTH-1:0] acc_r;

  logic [ACC_WIDTH-1:0]    prod_ext;
  logic [ACC_WIDTH-1:0]    acc_sum;
  logic [ACC_WIDTH+31:0]   bias_wide;
  logic [ACC_WIDTH-1:0]    z_sum;
  logic                    st_fire;
  logic                    accept;

  assign a_diff = $signed({in_act[7], in_act}) - $signed({cfg.izp[7], cfg.izp});
  assign w_diff = $signed({in_wgt[7], in_wgt}) - $signed({cfg.wzp[7], cfg.wzp});
  assign prod   = a_diff * w_diff;

  // A last word waits in the stage until the queue has room; others drain at once.
  assign st_fire  = st_valid_r && (!st_last_r || q_ready);
  assign in_ready = !st_valid_r || st_fire;
  assign accept   = in_valid && in_ready;

  assign prod_ext  = {{(ACC_WIDTH-idmr_pkg::PROD_W){st_prod_r[17]}}, st_prod_r};
  assign acc_sum   = acc_r + prod_ext;
  // bias enters zero-extended, truncated when the accumulator is narrower
  assign bias_wide = {{ACC_WIDTH{1'b0}}, st_bias_r};
  assign z_sum     = acc_sum + bias_wide[ACC_WIDTH-1:0];

  assign q_valid = st_valid_r && st_last_r;
  assign q_data  = {st_shift_r, st_mult_r, z_sum};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      if (accept) begin
        st_valid_r <= 1'b1;
      end else if (st_fire) begin
        st_valid_r <= 1'b0;
      end
      if (st_fire) begin
        acc_r <= st_last_r ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_prod_r  <= prod;
      st_last_r  <= in_last;
      st_bias_r  <= in_bias;
      st_mult_r  <= in_mult;
      st_shift_r <= in_shift;
    end
  end

endmodule

@@ hw/rtl/idmr_queue.sv @@
// Two-entry queue between the accumulator and the requantizer.
module idmr_queue #(
  parameter int DATA_W = 69
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              push;
  logic              pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/idmr_back.sv @@
// Back end: multiply, round, shift, saturate, add output zero point, clamp, output register.
module idmr_back #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  idmr_pkg::idmr_cfg_t cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [ACC_WIDTH+idmr_pkg::MULT_W+idmr_pkg::SHIFT_W-1:0] q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_value
);

  localparam int LO_W = ACC_WIDTH / 2;
  localparam int HI_W = ACC_WIDTH - LO_W;

  idmr_pkg::idmr_bstate_t state_r, state_nxt;

  logic [ACC_WIDTH-1:0]     z_r;
  logic [29:0]              mult_r;
  logic [6:0]               shift_r;
  logic [LO_W+29:0]         pp_lo_r;
  logic signed [HI_W+30:0]  pp_hi_r;
  logic [63:0]              p_r;
  logic                     out_valid_r;
  logic [7:0]               out_value_r;

  logic                     load_in;
  logic                     load_out;
  logic [LO_W+29:0]         pp_lo;
  logic signed [HI_W+30:0]  pp_hi;
  logic [63:0]              hi_ext;
  logic [63:0]              lo_ext;
  logic [63:0]              p_sum;
  logic                     sh_pos;
  logic                     sh_neg;
  logic [5:0]               half_amt;
  logic [63:0]              half;
  logic [63:0]              p_rnd;
  logic [6:0]               lsh_amt;
  logic [63:0]              p_shf;
  logic [31:0]              s32;
  logic signed [33:0]       res;
  logic [7:0]               clamp_val;

  // partial products: low half unsigned, high half signed
  assign pp_lo = z_r[LO_W-1:0] * mult_r;
  assign pp_hi = $signed(z_r[ACC_WIDTH-1:LO_W]) * $signed({1'b0, mult_r});

  assign hi_ext = {{(64-HI_W-31){pp_hi_r[HI_W+30]}}, pp_hi_r};
  assign lo_ext = {{(64-LO_W-30){1'b0}}, pp_lo_r};
  assign p_sum  = (hi_ext << LO_W) + lo_ext;

  assign sh_pos   = !shift_r[6] && (shift_r != 7'd0);
  assign sh_neg   = shift_r[6];
  assign half_amt = shift_r[5:0] - 6'd1;
  assign half     = 64'd1 << half_amt;
  assign p_rnd    = p_r[63] ? (p_r - half) : (p_r + half);
  // left amount is 1..64; a shift by 64 clears the word
  assign lsh_amt  = ~shift_r + 7'd1;

  always_comb begin
    if (sh_pos) begin
      p_shf = $signed(p_r) >>> shift_r[5:0];
    end else if (sh_neg) begin
      p_shf = p_r << lsh_amt;
    end else begin
      p_shf = p_r;
    end
  end

  always_comb begin
    if ($signed(p_r) > 64'sh0000_0000_7FFF_FFFF) begin
      s32 = 32'h7FFF_FFFF;
    end else if ($signed(p_r) < -64'sh0000_0000_8000_0000) begin
      s32 = 32'h8000_0000;
    end else begin
      s32 = p_r[31:0];
    end
    res = $signed({{2{s32[31]}}, s32}) + $signed({{26{cfg.ozp[7]}}, cfg.ozp});
    if (res < -34'sd128) begin
      clamp_val = 8'h80;
    end else if (res > 34'sd127) begin
      clamp_val = 8'h7F;
    end else begin
      clamp_val = res[7:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    load_in   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      idmr_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          load_in   = 1'b1;
          state_nxt = idmr_pkg::BK_MUL;
        end
      end
      idmr_pkg::BK_MUL: state_nxt = idmr_pkg::BK_ADD;
      idmr_pkg::BK_ADD: state_nxt = idmr_pkg::BK_RND;
      idmr_pkg::BK_RND: state_nxt = idmr_pkg::BK_SHF;
      idmr_pkg::BK_SHF: state_nxt = idmr_pkg::BK_SAT;
      idmr_pkg::BK_SAT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = idmr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = idmr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idmr_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      z_r     <= q_data[ACC_WIDTH-1:0];
      mult_r  <= q_data[ACC_WIDTH+29:ACC_WIDTH];
      shift_r <= q_data[ACC_WIDTH+36:ACC_WIDTH+30];
    end
    if (state_r == idmr_pkg::BK_MUL) begin
      pp_lo_r <= pp_lo;
      pp_hi_r <= pp_hi;
    end
    if (state_r == idmr_pkg::BK_ADD) begin
      p_r <= p_sum;
    end else if (state_r == idmr_pkg::BK_RND && sh_pos) begin
      p_r <= p_rnd;
    end else if (state_r == idmr_pkg::BK_SHF) begin
      p_r <= p_shf;
    end
    if (load_out) begin
      out_value_r <= clamp_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

@@ hw/rtl/int8_dense_mac_requantize.sv @@
// Top level of the int8 dense MAC requantize block.
//
// One neuron per run of input words. Each in_ word carries an activation and
// a weight; in_tlast marks the final pair, whose word also carries the bias,
// the 30-bit fraction multiplier and the signed shift. The front end accepts
// one word per clock and accumulates one product per clock, but a last word
// waits while the queue is full. On the last word the biased sum enters a
// two-entry queue; the requantizer takes it from there and delivers one
// int8 word on out_ after the accumulator stage, the queue and five
// requantize steps ending in the output register. A requantize pass spans
// taking the entry and the five steps, so while out_tready is high, runs no
// shorter than a pass stream at one word per clock; shorter runs back up into
// the queue and then in_tready drops until the requantizer frees an entry.
// If out_tready stays low the result waits in the output register, the
// requantizer holds its next value, and the queue and front end fill up
// before input is stalled.
// The cfg_ APB port holds the input, weight and output zero points at byte
// addresses 0, 4 and 8; write them only while no run is in progress.
// Synchronous reset (rst_n low) clears the accumulator, queue and output
// valid and restores the zero points to -128, 0 and -128.
module int8_dense_mac_requantize #(
  parameter int ACC_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // activation[7:0], weight[15:8], bias[47:16],
                                 // multiplier[77:48], shift[84:78], zero pad
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // output_value[7:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int QD_W = ACC_WIDTH + idmr_pkg::MULT_W + idmr_pkg::SHIFT_W;

  idmr_pkg::idmr_cfg_t cfg_r;
  logic                cfg_wr;
  logic                q_in_valid;
  logic                q_in_ready;
  logic [QD_W-1:0]     q_in_data;
  logic                q_out_valid;
  logic                q_out_ready;
  logic [QD_W-1:0]     q_out_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.izp <= idmr_pkg::IZP_RESET;
      cfg_r.wzp <= idmr_pkg::WZP_RESET;
      cfg_r.ozp <= idmr_pkg::OZP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        idmr_pkg::REG_IZP: cfg_r.izp <= cfg_pwdata[7:0];
        idmr_pkg::REG_WZP: cfg_r.wzp <= cfg_pwdata[7:0];
        idmr_pkg::REG_OZP: cfg_r.ozp <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      idmr_pkg::REG_IZP: cfg_prdata = {24'd0, cfg_r.izp};
      idmr_pkg::REG_WZP: cfg_prdata = {24'd0, cfg_r.wzp};
      idmr_pkg::REG_OZP: cfg_prdata = {24'd0, cfg_r.ozp};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  idmr_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_act   (in_tdata[7:0]),
    .in_wgt   (in_tdata[15:8]),
    .in_last  (in_tlast),
    .in_bias  (in_tdata[47:16]),
    .in_mult  (in_tdata[77:48]),
    .in_shift (in_tdata[84:78]),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  idmr_queue #(.DATA_W(QD_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_in_valid),
    .wr_ready (q_in_ready),
    .wr_data  (q_in_data),
    .rd_valid (q_out_valid),
    .rd_ready (q_out_ready),
    .rd_data  (q_out_data)
  );

  idmr_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_data    (q_out_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata)
  );

endmodule

@@ hw/rtl/idmr_checker.sv @@
// Port-level checker for the int8 dense MAC requantize block, bound to the top level.
module idmr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [87:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [3:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // no result is presented in the first cycle out of reset
  a_reset_clears: assert property (@(posedge clk)
    rst_n && ($past(rst_n) == 1'b0) |-> !out_tvalid)
    else $error("output valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

  // a register read right after a write returns the written byte
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
    && cfg_psel && !cfg_pwrite && (cfg_paddr[3:2] == $past(cfg_paddr[3:2]))
    && (cfg_paddr[3:2] != 2'd3)
    |-> cfg_prdata == {24'd0, $past(cfg_pwdata[7:0])})
    else $error("register readback mismatch");

endmodule

bind int8_dense_mac_requantize idmr_checker u_idmr_checker (.*);
